@@ sv/skc_pkg.sv @@
// ----------------------------------------------------------------------------
// skc_pkg
// Widths, codes and shared types of the symmetric-kernel convolution core.
// ----------------------------------------------------------------------------
package skc_pkg;

  localparam int PIX_W       = 16;
  localparam int WGT_W       = 16;
  localparam int OFS_W       = 2;
  localparam int GRP_W       = PIX_W + 2;          // up to four mirrored taps
  localparam int PROD_W      = GRP_W + WGT_W + 1;  // signed group times unsigned weight
  localparam int OUT_COL_W   = 12;
  localparam int OUT_ROW_W   = 10;
  localparam int OUT_VAL_W   = 24;
  localparam int COL_CNT_W   = 13;
  localparam int ROW_CNT_W   = 11;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int LINE_ADDR_W = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int RND_SHIFT   = 15;

  localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT    = 2'd1;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_PIXEL  = 1'b1;

  localparam logic [COL_CNT_W-1:0] COL_CNT_RST = 13'd4096;
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_RST = 11'd1024;

  typedef struct packed {
    logic [OUT_COL_W-1:0] centre_col;
    logic [OUT_ROW_W-1:0] centre_row;
    logic                 last;
  } meta_t;

  typedef struct packed {
    logic                   is_pixel;
    logic [OFS_W-1:0]       wcol;
    logic [OFS_W-1:0]       wrow;
    logic [PIX_W-1:0]       data;       // pixel or weight
    logic [LINE_ADDR_W-1:0] line_addr;
    logic                   emit;       // window centre is interior
    meta_t                  meta;
  } cmd_t;

endpackage

@@ sv/skc_if.sv @@
// ----------------------------------------------------------------------------
// skc_if
// Valid/ready channels of the convolution core: items, results, config.
// ----------------------------------------------------------------------------
interface skc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [skc_pkg::OFS_W-1:0]       weight_col;
  logic [skc_pkg::OFS_W-1:0]       weight_row;
  logic [skc_pkg::WGT_W-1:0]       weight_value;
  logic signed [skc_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, func, weight_col, weight_row, weight_value, pixel_value,
                  input ready);
  modport sink (input valid, func, weight_col, weight_row, weight_value, pixel_value,
                output ready);
endinterface

interface skc_out_if;
  logic                                valid;
  logic                                ready;
  logic [skc_pkg::OUT_COL_W-1:0]       centre_col;
  logic [skc_pkg::OUT_ROW_W-1:0]       centre_row;
  logic signed [skc_pkg::OUT_VAL_W-1:0] filtered_value;
  logic                                frame_last;

  modport source (output valid, centre_col, centre_row, filtered_value, frame_last,
                  input ready);
  modport sink (input valid, centre_col, centre_row, filtered_value, frame_last,
                output ready);
endinterface

interface skc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [skc_pkg::CFG_ADDR_W-1:0] addr;
  logic [skc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ sv/skc_front.sv @@
// ----------------------------------------------------------------------------
// skc_front
// Takes items and config writes, tracks the frame position and turns each
// pixel and each in-range weight write into a command for the compute back end.
// ----------------------------------------------------------------------------
module skc_front #(
  parameter int KERNEL_RADIUS = 2,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  skc_in_if.sink         in_i,
  skc_cfg_if.sink        cfg_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output skc_pkg::cmd_t  cmd_o
);

  localparam int SPAN = 2 * KERNEL_RADIUS + 1;
  localparam int HIST = 2 * KERNEL_RADIUS;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);

  logic [skc_pkg::COL_CNT_W-1:0] col_cnt_q;
  logic [skc_pkg::ROW_CNT_W-1:0] row_cnt_q;
  logic [CW-1:0]                 col_q;
  logic [RW-1:0]                 row_q;
  logic [31:0]                   col_lim;
  logic [31:0]                   row_lim;
  logic [CW:0]                   cols;
  logic [RW:0]                   rows;
  logic                          col_end;
  logic                          row_end;
  logic                          px_go;
  logic                          cfg_go;
  logic                          wgt_ok;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = push_ready_i;

  assign cfg_go = cfg_i.valid && cfg_i.ready;
  assign px_go  = in_i.valid && in_i.ready && (in_i.func == skc_pkg::FUNC_PIXEL);

  // working frame size, clamped to what the window and line memory support
  always_comb begin
    col_lim = 32'(col_cnt_q);
    row_lim = 32'(row_cnt_q);
    if (col_lim < 32'(SPAN)) begin
      col_lim = 32'(SPAN);
    end else if (col_lim > 32'(MAX_WIDTH)) begin
      col_lim = 32'(MAX_WIDTH);
    end
    if (row_lim < 32'(SPAN)) begin
      row_lim = 32'(SPAN);
    end else if (row_lim > 32'(MAX_HEIGHT)) begin
      row_lim = 32'(MAX_HEIGHT);
    end
  end

  assign cols    = (CW + 1)'(col_lim);
  assign rows    = (RW + 1)'(row_lim);
  assign col_end = ((CW + 1)'(col_q) + (CW + 1)'(1)) == cols;
  assign row_end = ((RW + 1)'(row_q) + (RW + 1)'(1)) == rows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= skc_pkg::COL_CNT_RST;
      row_cnt_q <= skc_pkg::ROW_CNT_RST;
      col_q     <= '0;
      row_q     <= '0;
    end else if (cfg_go) begin
      unique case (cfg_i.addr)
        skc_pkg::CFG_COLUMN_COUNT: begin
          col_cnt_q <= cfg_i.data[skc_pkg::COL_CNT_W-1:0];
          col_q     <= '0;
          row_q     <= '0;
        end
        skc_pkg::CFG_ROW_COUNT: begin
          row_cnt_q <= cfg_i.data[skc_pkg::ROW_CNT_W-1:0];
          col_q     <= '0;
          row_q     <= '0;
        end
        default: begin
        end
      endcase
    end else if (px_go) begin
      if (row_end) begin
        row_q <= '0;
        col_q <= col_end ? '0 : col_q + CW'(1);
      end else begin
        row_q <= row_q + RW'(1);
      end
    end
  end

  // weight writes beyond the stored quadrant are dropped here
  assign wgt_ok = (int'(in_i.weight_col) <= KERNEL_RADIUS) &&
                  (int'(in_i.weight_row) <= KERNEL_RADIUS);

  assign push_valid_o = in_i.valid && ((in_i.func == skc_pkg::FUNC_PIXEL) || wgt_ok);

  always_comb begin
    cmd_o.is_pixel        = (in_i.func == skc_pkg::FUNC_PIXEL);
    cmd_o.wcol            = in_i.weight_col;
    cmd_o.wrow            = in_i.weight_row;
    cmd_o.data            = cmd_o.is_pixel ? in_i.pixel_value : in_i.weight_value;
    cmd_o.line_addr       = skc_pkg::LINE_ADDR_W'(row_q);
    cmd_o.emit            = (col_q >= CW'(HIST)) && (row_q >= RW'(HIST));
    cmd_o.meta.centre_col = skc_pkg::OUT_COL_W'(col_q - CW'(KERNEL_RADIUS));
    cmd_o.meta.centre_row = skc_pkg::OUT_ROW_W'(row_q - RW'(KERNEL_RADIUS));
    cmd_o.meta.last       = col_end && row_end;
  end

endmodule

@@ sv/skc_queue.sv @@
// ----------------------------------------------------------------------------
// skc_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module skc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  skc_pkg::cmd_t  push_cmd_i,
  output logic           head_valid_o,
  input  logic           pop_i,
  output skc_pkg::cmd_t  head_cmd_o
);

  localparam int PW = $clog2(skc_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(skc_pkg::QUEUE_DEPTH + 1);

  skc_pkg::cmd_t   buf_q [skc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q;
  logic [PW-1:0]   rd_ptr_q;
  logic [NW-1:0]   cnt_q;
  logic            push_go;
  logic            pop_go;

  assign push_ready_o = (cnt_q != NW'(skc_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = buf_q[rd_ptr_q];
  assign push_go      = push_valid_i && push_ready_o;
  assign pop_go       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_go) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_go) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      priority if (push_go && !pop_go) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_go && !push_go) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_go) begin
      buf_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ sv/skc_back.sv @@
// ----------------------------------------------------------------------------
// skc_back
// Line memory, window register, mirrored pre-add, quadrant multipliers,
// registered adder tree, rounding and saturation, result register.
// ----------------------------------------------------------------------------
module skc_back #(
  parameter int KERNEL_RADIUS = 2,
  parameter int MAX_HEIGHT    = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  skc_pkg::cmd_t  head_cmd_i,
  output logic           pop_o,
  skc_out_if.source      out_o
);

  localparam int KR   = KERNEL_RADIUS;
  localparam int SPAN = 2 * KR + 1;
  localparam int HIST = 2 * KR;
  localparam int QUAD = KR + 1;
  localparam int NG   = QUAD * QUAD;
  localparam int LV   = $clog2(NG);
  localparam int NP   = 1 << LV;
  localparam int SW   = skc_pkg::PROD_W + LV;
  localparam int QW   = SW - skc_pkg::RND_SHIFT;
  localparam int AW   = $clog2(MAX_HEIGHT);
  localparam int PW   = skc_pkg::PIX_W;
  localparam int LW   = HIST * PW;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1 << (skc_pkg::RND_SHIFT - 1));
  localparam logic signed [QW-1:0] SAT_HI   = QW'(24'sh7FFFFF);
  localparam logic signed [QW-1:0] SAT_LO   = QW'(24'sh800000);

  logic                       adv;

  // stage 1: line memory read data
  logic [LW-1:0]              line_mem [MAX_HEIGHT];
  logic [LW-1:0]              rd_q;
  logic                       s1_vld_q;
  skc_pkg::cmd_t              s1_q;
  logic                       s1_px_go;
  logic [SPAN*PW-1:0]         new_row;

  // stage 2: window
  logic [PW-1:0]              win_q [SPAN][SPAN];
  logic                       s2_vld_q;
  skc_pkg::cmd_t              s2_q;
  logic signed [skc_pkg::GRP_W-1:0] grp_d [QUAD][QUAD];

  // stage 3: pre-added groups and weights
  logic signed [skc_pkg::GRP_W-1:0] grp_q [QUAD][QUAD];
  logic [skc_pkg::WGT_W-1:0]  weight_q [QUAD][QUAD];
  logic                       s3_vld_q;
  skc_pkg::cmd_t              s3_q;
  logic signed [SW-1:0]       prod_d [NG];

  // adder tree, heap order: node 1 is the root, leaves start at NP
  logic signed [SW-1:0]       node_q [1:2*NP-1];
  logic                       p_vld_q [LV+1];
  skc_pkg::meta_t             p_meta_q [LV+1];

  logic signed [SW-1:0]       rnd;
  logic signed [QW-1:0]       q_full;
  logic signed [skc_pkg::OUT_VAL_W-1:0] q_sat;

  logic                       out_vld_q;
  skc_pkg::meta_t             out_meta_q;
  logic signed [skc_pkg::OUT_VAL_W-1:0] out_val_q;

  // whole pipeline moves together unless a finished result is held
  assign adv   = !out_vld_q || out_o.ready;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= head_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= head_cmd_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // read-modify-write per pixel: a word holds the previous HIST columns of a row
  assign s1_px_go = adv && s1_vld_q && s1_q.is_pixel;
  assign new_row  = {s1_q.data, rd_q};

  always_ff @(posedge clk_i) begin
    if (adv && head_valid_i) begin
      rd_q <= line_mem[head_cmd_i.line_addr[AW-1:0]];
    end
    if (s1_px_go) begin
      line_mem[s1_q.line_addr[AW-1:0]] <= {s1_q.data, rd_q[LW-1:PW]};
    end
  end

  // window rows shift by one per pixel, newest row on top
  always_ff @(posedge clk_i) begin
    if (s1_px_go) begin
      for (int a = 0; a < HIST; a++) begin
        win_q[a] <= win_q[a+1];
      end
      for (int b = 0; b < SPAN; b++) begin
        win_q[HIST][b] <= new_row[b*PW +: PW];
      end
    end
  end

  // taps sharing one mirrored weight are summed first
  for (genvar wc = 0; wc < QUAD; wc++) begin : g_gc
    for (genvar wr = 0; wr < QUAD; wr++) begin : g_gr
      logic signed [skc_pkg::GRP_W-1:0] t0, t1, t2, t3;
      assign t0 = skc_pkg::GRP_W'($signed(win_q[KR-wr][KR-wc]));
      assign t1 = (wr > 0) ? skc_pkg::GRP_W'($signed(win_q[KR+wr][KR-wc])) : '0;
      assign t2 = (wc > 0) ? skc_pkg::GRP_W'($signed(win_q[KR-wr][KR+wc])) : '0;
      assign t3 = (wr > 0 && wc > 0) ?
                  skc_pkg::GRP_W'($signed(win_q[KR+wr][KR+wc])) : '0;
      assign grp_d[wc][wr] = t0 + t1 + t2 + t3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grp_q <= grp_d;
    end
  end

  // weights change in order with pixels, right where they are multiplied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUAD; i++) begin
        for (int j = 0; j < QUAD; j++) begin
          weight_q[i][j] <= '0;
        end
      end
    end else if (adv && s3_vld_q && !s3_q.is_pixel) begin
      for (int i = 0; i < QUAD; i++) begin
        for (int j = 0; j < QUAD; j++) begin
          if (int'(s3_q.wcol) == i && int'(s3_q.wrow) == j) begin
            weight_q[i][j] <= s3_q.data;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QUAD; i++) begin
      for (int j = 0; j < QUAD; j++) begin
        prod_d[i*QUAD+j] = SW'(skc_pkg::PROD_W'(grp_q[i][j]) *
                               skc_pkg::PROD_W'($signed({1'b0, weight_q[i][j]})));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int g = 0; g < NP; g++) begin
        node_q[NP+g] <= (g < NG) ? prod_d[g] : '0;
      end
    end
  end

  for (genvar n = 1; n < NP; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      if (adv) begin
        node_q[n] <= node_q[2*n] + node_q[2*n+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LV; k++) begin
        p_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      p_vld_q[0] <= s3_vld_q && s3_q.is_pixel && s3_q.emit;
      for (int k = 1; k <= LV; k++) begin
        p_vld_q[k] <= p_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_meta_q[0] <= s3_q.meta;
      for (int k = 1; k <= LV; k++) begin
        p_meta_q[k] <= p_meta_q[k-1];
      end
    end
  end

  // round half up past the UQ1.15 weight fraction, then clip to 24 bits
  assign rnd    = node_q[1] + RND_HALF;
  assign q_full = $signed(rnd[SW-1:skc_pkg::RND_SHIFT]);

  always_comb begin
    priority if (q_full > SAT_HI) begin
      q_sat = 24'sh7FFFFF;
    end else if (q_full < SAT_LO) begin
      q_sat = 24'sh800000;
    end else begin
      q_sat = skc_pkg::OUT_VAL_W'(q_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= p_vld_q[LV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && p_vld_q[LV]) begin
      out_meta_q <= p_meta_q[LV];
      out_val_q  <= q_sat;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.centre_col     = out_meta_q.centre_col;
  assign out_o.centre_row     = out_meta_q.centre_row;
  assign out_o.filtered_value = out_val_q;
  assign out_o.frame_last     = out_meta_q.last;

endmodule

@@ sv/symmetric_kernel_2d_convolution_core.sv @@
// ----------------------------------------------------------------------------
// symmetric_kernel_2d_convolution_core
// Streaming 2-D convolution, column-major pixels, mirror-symmetric kernel.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless a finished result is held at the output;
//   each pixel does one read and one write of the line memory, and every stage
//   of the back end is fully pipelined
// reset: positions zero, column_count 4096, row_count 1024, weights zero;
//   line memory and window are not cleared and need no clearing pass
module symmetric_kernel_2d_convolution_core #(
  parameter int KERNEL_RADIUS = 2,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skc_in_if.sink     in_i,
  skc_cfg_if.sink    cfg_i,
  skc_out_if.source  out_o
);

  logic           push_valid;
  logic           push_ready;
  skc_pkg::cmd_t  push_cmd;
  logic           head_valid;
  logic           pop;
  skc_pkg::cmd_t  head_cmd;

  skc_front #(
    .KERNEL_RADIUS (KERNEL_RADIUS),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .MAX_WIDTH     (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  skc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_cmd_o   (head_cmd)
  );

  skc_back #(
    .KERNEL_RADIUS (KERNEL_RADIUS),
    .MAX_HEIGHT    (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ sv/skc_checker.sv @@
// ----------------------------------------------------------------------------
// skc_checker
// Port-level checks on result order and hold behavior of the core.
// ----------------------------------------------------------------------------
module skc_checker #(
  parameter int KERNEL_RADIUS = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [skc_pkg::OUT_COL_W-1:0]       centre_col_i,
  input  logic [skc_pkg::OUT_ROW_W-1:0]       centre_row_i,
  input  logic signed [skc_pkg::OUT_VAL_W-1:0] filtered_value_i,
  input  logic                                frame_last_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i
);

  localparam logic [skc_pkg::OUT_COL_W-1:0] R_COL = skc_pkg::OUT_COL_W'(KERNEL_RADIUS);
  localparam logic [skc_pkg::OUT_ROW_W-1:0] R_ROW = skc_pkg::OUT_ROW_W'(KERNEL_RADIUS);

  logic                          out_go;
  logic                          prev_seen_q;
  logic                          prev_last_q;
  logic [skc_pkg::OUT_COL_W-1:0] prev_col_q;
  logic [skc_pkg::OUT_ROW_W-1:0] prev_row_q;

  assign out_go = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_seen_q <= 1'b0;
      prev_last_q <= 1'b0;
      prev_col_q  <= '0;
      prev_row_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      prev_seen_q <= 1'b0;
    end else if (out_go) begin
      prev_seen_q <= 1'b1;
      prev_last_q <= frame_last_i;
      prev_col_q  <= centre_col_i;
      prev_row_q  <= centre_row_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(centre_col_i) &&
      $stable(centre_row_i) && $stable(filtered_value_i) && $stable(frame_last_i))
    else $error("result changed while stalled");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> centre_col_i >= R_COL && centre_row_i >= R_ROW)
    else $error("result centre outside the interior");

  a_new_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_go && prev_seen_q && prev_last_q |-> centre_col_i == R_COL && centre_row_i == R_ROW)
    else $error("frame did not restart at the first interior position");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_go && prev_seen_q && !prev_last_q |->
      (centre_col_i == prev_col_q && centre_row_i == prev_row_q + 10'd1) ||
      (centre_col_i == prev_col_q + 12'd1 && centre_row_i == R_ROW))
    else $error("results out of scan order");

endmodule

bind symmetric_kernel_2d_convolution_core skc_checker #(
  .KERNEL_RADIUS (KERNEL_RADIUS)
) u_skc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .centre_col_i     (out_o.centre_col),
  .centre_row_i     (out_o.centre_row),
  .filtered_value_i (out_o.filtered_value),
  .frame_last_i     (out_o.frame_last),
  .cfg_valid_i      (cfg_i.valid),
  .cfg_ready_i      (cfg_i.ready)
);
